// ===== rtl/csm_pkg.sv =====
// csm_pkg: shared types, codes and glyph table for the segment marquee
package csm_pkg;

	// operation codes of an input request
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// result kinds
	localparam logic KIND_CHAIN = 1'b0;
	localparam logic KIND_SCAN  = 1'b1;

	// received byte codes
	localparam logic [7:0] CODE_FREEZE  = 8'd17;
	localparam logic [7:0] CODE_RESUME  = 8'd18;
	localparam logic [7:0] CODE_REFRESH = 8'd19;
	localparam logic [7:0] FIRST_CHAR   = 8'd32;
	localparam logic [7:0] FIRST_DIRECT = 8'd127;

	localparam logic [7:0] DIGIT_RESET = 8'h55;
	localparam int unsigned GLYPHS = 95;

	// decoded byte, passed from the pattern decoder to the top level
	typedef struct packed {
		logic       is_char;
		logic       freeze;
		logic       resume;
		logic       refresh;
		logic [7:0] pattern;
	} byte_dec_t;

	localparam logic [7:0] GLYPH_ROM [GLYPHS] = '{
		8'h00, 8'h5E, 8'h18, 8'h44, 8'h2E, 8'h2E, 8'h17,
		8'h08, 8'h0C, 8'h22, 8'h5C, 8'h49, 8'h22, 8'h40,
		8'h20, 8'h11, 8'h3F, 8'h30, 8'h36, 8'h76, 8'h78,
		8'h6E, 8'h6F, 8'h34, 8'h7F, 8'h7C, 8'h06, 8'h26,
		8'h03, 8'h42, 8'h0C, 8'h55, 8'h1F, 8'h7D, 8'h7F,
		8'h0F, 8'h36, 8'h4F, 8'h4D, 8'h2F, 8'h79, 8'h09,
		8'h33, 8'h5B, 8'h0B, 8'h25, 8'h3D, 8'h3F, 8'h5D,
		8'h5E, 8'h75, 8'h6E, 8'h0D, 8'h3B, 8'h3B, 8'h1A,
		8'h46, 8'h7A, 8'h57, 8'h0E, 8'h28, 8'h36, 8'h1C,
		8'h02, 8'h10, 8'h77, 8'h6B, 8'h43, 8'h73, 8'h5F,
		8'h4D, 8'h7E, 8'h69, 8'h01, 8'h22, 8'h62,
		8'h30, 8'h65, 8'h61, 8'h63, 8'h5D,
		8'h7C, 8'h41, 8'h68,
		8'h4B, 8'h23, 8'h23,
		8'h27, 8'h21, 8'h59, 8'h51,
		8'h70, 8'h48, 8'h39, 8'h04
	};

	// glyph lookup, zero beyond the table
	function automatic logic [7:0] glyph(input logic [6:0] idx);
		logic [7:0] g;
		g = 8'h00;
		if (32'(idx) < GLYPHS) begin
			g = GLYPH_ROM[idx];
		end
		return g;
	endfunction

endpackage

// ===== rtl/csm_pattern.sv =====
// csm_pattern: decodes a received byte into control flags and a remapped pattern
module csm_pattern (
	input  logic [7:0]          rx_byte,
	output csm_pkg::byte_dec_t  dec
);

	logic [7:0] raw;
	logic [7:0] char_idx;

	assign char_idx = rx_byte - csm_pkg::FIRST_CHAR;

	always_comb begin
		if (rx_byte < csm_pkg::FIRST_DIRECT) begin
			raw = csm_pkg::glyph(char_idx[6:0]);
		end else begin
			raw = {1'b0, rx_byte[6:0]};
		end
	end

	assign dec.is_char = (rx_byte >= csm_pkg::FIRST_CHAR);
	assign dec.freeze  = (rx_byte == csm_pkg::CODE_FREEZE);
	assign dec.resume  = (rx_byte == csm_pkg::CODE_RESUME);
	assign dec.refresh = (rx_byte == csm_pkg::CODE_RESUME) ||
		(rx_byte == csm_pkg::CODE_REFRESH);
	// bits 5 and 6 move up one place, bit 5 left clear
	assign dec.pattern = {raw[6:5], 1'b0, raw[4:0]};

endmodule

// ===== rtl/chainable_segment_marquee_unit.sv =====
// chainable_segment_marquee_unit: top level of the chainable seven-segment marquee
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_ready  | operation, rx_byte
//  out     | output    | out_valid / out_ready| result_kind, chain_byte, scan_row,
//          |           |                      | scan_col, segment_on
//
// decode, digit shift and scan lookup sit between
// the input ports and a single result register, so a request is taken every cycle
// while the result register is empty or being drained.
// arst_n clears the digits to 0x55, sets scrolling and zeroes the scan position.
// a stalled result holds in_ready low; control codes give no result.
module chainable_segment_marquee_unit #(
	parameter int unsigned DIGITS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       result_kind,
	output logic [7:0] chain_byte,
	output logic [1:0] scan_row,
	output logic [2:0] scan_col,
	output logic       segment_on
);

	localparam int unsigned ROW_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(DIGITS - 1);

	// digit storage and scan position
	logic [7:0]       shown_q  [DIGITS];
	logic [7:0]       shadow_q [DIGITS];
	logic [7:0]       shown_d  [DIGITS];
	logic [7:0]       shadow_d [DIGITS];
	logic             scrolling_q, scrolling_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic [2:0]       col_q, col_d;

	// result register
	logic       out_valid_q;
	logic       kind_q;
	logic [7:0] chain_q;
	logic [1:0] row_out_q;
	logic [2:0] col_out_q;
	logic       seg_q;

	// result of the request being taken
	logic       res_valid;
	logic       res_kind;
	logic [7:0] res_chain;
	logic [1:0] res_row;
	logic [2:0] res_col;
	logic       res_seg;

	logic               take;
	logic [31:0]        row_ext;
	csm_pkg::byte_dec_t dec;

	csm_pattern u_pattern (
		.rx_byte (rx_byte),
		.dec     (dec)
	);

	// a new request enters whenever the result register is free this cycle
	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;
	assign row_ext  = 32'(row_q);

	always_comb begin
		shown_d     = shown_q;
		shadow_d    = shadow_q;
		scrolling_d = scrolling_q;
		row_d       = row_q;
		col_d       = col_q;
		res_valid   = 1'b0;
		res_kind    = csm_pkg::KIND_CHAIN;
		res_chain   = 8'h00;
		res_row     = 2'd0;
		res_col     = 3'd0;
		res_seg     = 1'b0;
		if (operation == csm_pkg::OP_TICK) begin
			// report the current position, then advance the column, and the row when the column wraps
			res_valid = 1'b1;
			res_kind  = csm_pkg::KIND_SCAN;
			res_row   = row_ext[1:0];
			res_col   = col_q;
			res_seg   = shown_q[row_q][col_q];
			col_d     = col_q + 3'd1;
			if (col_q == 3'd7) begin
				row_d = (row_q == ROW_LAST) ? '0 : row_q + ROW_W'(1);
			end
		end else if (dec.is_char) begin
			// shift into the shown digits, or the shadow digits while frozen; oldest digit goes down the chain
			res_valid = 1'b1;
			if (scrolling_q) begin
				res_chain  = shown_q[DIGITS-1];
				for (int i = 1; i < DIGITS; i++) begin
					shown_d[i] = shown_q[i-1];
				end
				shown_d[0] = dec.pattern;
			end else begin
				res_chain  = shadow_q[DIGITS-1];
				for (int i = 1; i < DIGITS; i++) begin
					shadow_d[i] = shadow_q[i-1];
				end
				shadow_d[0] = dec.pattern;
			end
		end else if (dec.freeze) begin
			scrolling_d = 1'b0;
			shadow_d    = shown_q;
		end else if (dec.refresh) begin
			// resume also copies the shadow digits back
			if (dec.resume) begin
				scrolling_d = 1'b1;
			end
			shown_d = shadow_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				shown_q[i]  <= csm_pkg::DIGIT_RESET;
				shadow_q[i] <= csm_pkg::DIGIT_RESET;
			end
			scrolling_q <= 1'b1;
			row_q       <= '0;
			col_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				shown_q     <= shown_d;
				shadow_q    <= shadow_d;
				scrolling_q <= scrolling_d;
				row_q       <= row_d;
				col_q       <= col_d;
				out_valid_q <= res_valid;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded only with a request that gives a result
	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			kind_q    <= res_kind;
			chain_q   <= res_chain;
			row_out_q <= res_row;
			col_out_q <= res_col;
			seg_q     <= res_seg;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign chain_byte  = chain_q;
	assign scan_row    = row_out_q;
	assign scan_col    = col_out_q;
	assign segment_on  = seg_q;

endmodule

// ===== rtl/csm_checker.sv =====
// csm_checker: port-level checks of the segment marquee, bound to the top level
module csm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       operation,
	input logic [7:0] rx_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic       result_kind,
	input logic [7:0] chain_byte,
	input logic [1:0] scan_row,
	input logic [2:0] scan_col,
	input logic       segment_on
);

	// a stalled result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a tick request always gives a scan result in the next cycle
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == csm_pkg::OP_TICK |=>
		out_valid && result_kind == csm_pkg::KIND_SCAN)
		else $error("tick request gave no scan result");

	// a control code gives no result
	a_ctrl_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == csm_pkg::OP_BYTE &&
		rx_byte < csm_pkg::FIRST_CHAR |=> !out_valid)
		else $error("control code gave a result");

	// unused fields of each result kind are zero
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		(result_kind == csm_pkg::KIND_SCAN && chain_byte == 8'h00) ||
		(result_kind == csm_pkg::KIND_CHAIN && scan_row == 2'd0 &&
		scan_col == 3'd0 && !segment_on))
		else $error("result carries stray fields");

endmodule

bind chainable_segment_marquee_unit csm_checker u_csm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.operation   (operation),
	.rx_byte     (rx_byte),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.result_kind (result_kind),
	.chain_byte  (chain_byte),
	.scan_row    (scan_row),
	.scan_col    (scan_col),
	.segment_on  (segment_on)
);
